/* src/nip_pkg.sv */
// Package: shared types, register indexes and reset values of the NEC IR pulse decoder.
`default_nettype none
package nip_pkg;

  localparam int unsigned NumRegs      = 8;
  localparam int unsigned RegIdxW      = 3;
  localparam int unsigned RegW         = 16;
  localparam int unsigned PulseW       = 16;
  localparam int unsigned IdleW        = 4;
  localparam int unsigned FrameW       = 32;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned TimeoutTicks = 14;

  typedef enum logic [1:0] {
    KIND_RISE = 2'd0,
    KIND_FALL = 2'd1,
    KIND_TICK = 2'd2,
    KIND_SCAN = 2'd3
  } kind_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_ZERO_MIN   = 3'd0,
    REG_ZERO_MAX   = 3'd1,
    REG_ONE_MIN    = 3'd2,
    REG_ONE_MAX    = 3'd3,
    REG_REPEAT_MIN = 3'd4,
    REG_REPEAT_MAX = 3'd5,
    REG_LEADER_MIN = 3'd6,
    REG_LEADER_MAX = 3'd7
  } reg_idx_e;

  typedef logic [NumRegs-1:0][RegW-1:0] reg_file_t;

  localparam reg_file_t RegResetVals = {
    16'd4700, 16'd4200, 16'd2600, 16'd2200,
    16'd1800, 16'd1400, 16'd800,  16'd300
  };

  typedef struct packed {
    logic is_zero;
    logic is_one;
    logic is_repeat;
    logic is_leader;
  } pulse_class_t;

endpackage
`default_nettype wire

/* src/nec_ir_pulse_decoder_top.sv */
// Top level of the NEC IR pulse decoder: input register, classifier, core, config registers.
//
// Usage: each input beat is one event (kind_i: rise, fall with pulse_width_i, timer
// tick, or scan). Only a scan beat produces a result beat carrying key_code_o,
// repeat_count_o and leader_active_o; other kinds update state silently.
// Input and output use valid/ready. An accepted beat lands in an input register;
// from there the core classifies the pulse, updates state and, for a scan,
// loads the result register, where the result is held until it is taken.
// Throughput: one beat per cycle, except while a scan stalls behind a pending result.
// When the receiver stalls, one result waits in the output register; non-scan
// beats keep flowing, and a second scan then waits in the input register, holding
// in_ready_o low, until the pending result is taken.
// Reset clears decoder state and loads the default window bounds; result data is not reset.
// Config writes (cfg_we_i) take effect from the next cycle and belong in idle periods.
`default_nettype none
module nec_ir_pulse_decoder_top #(
  parameter int unsigned TIMEOUT_TICKS = nip_pkg::TimeoutTicks
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [nip_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  wire logic [nip_pkg::RegW-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   kind_i,
  input  wire logic [nip_pkg::PulseW-1:0]   pulse_width_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [nip_pkg::ByteW-1:0]         key_code_o,
  output logic [nip_pkg::ByteW-1:0]         repeat_count_o,
  output logic                              leader_active_o
);

  logic                          s1_valid_q, s1_valid_d;
  logic [1:0]                    s1_kind_q;
  logic [nip_pkg::PulseW-1:0]    s1_width_q;
  logic                          item_taken;
  logic                          in_fire;
  nip_pkg::reg_file_t            regs;
  nip_pkg::pulse_class_t         pclass;

  assign in_ready_o = !s1_valid_q || item_taken;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (item_taken) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= kind_i;
      s1_width_q <= pulse_width_i;
    end
  end

  nip_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .regs_o     (regs)
  );

  nip_classify u_classify (
    .pulse_width_i (s1_width_q),
    .regs_i        (regs),
    .class_o       (pclass)
  );

  nip_core #(
    .TIMEOUT_TICKS (TIMEOUT_TICKS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (s1_valid_q),
    .kind_i          (nip_pkg::kind_e'(s1_kind_q)),
    .class_i         (pclass),
    .item_taken_o    (item_taken),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .key_code_o      (key_code_o),
    .repeat_count_o  (repeat_count_o),
    .leader_active_o (leader_active_o)
  );

endmodule
`default_nettype wire

/* src/nip_cfg_regs.sv */
// Window bound registers written through the configuration port.
`default_nettype none
module nip_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [nip_pkg::RegIdxW-1:0] cfg_idx_i,
  input  wire logic [nip_pkg::RegW-1:0]    cfg_data_i,
  output nip_pkg::reg_file_t               regs_o
);

  nip_pkg::reg_file_t regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= nip_pkg::RegResetVals;
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign regs_o = regs_q;

endmodule
`default_nettype wire

/* src/nip_classify.sv */
// Sorts a pulse width into the leader, data zero, data one and repeat windows.
`default_nettype none
module nip_classify (
  input  wire logic [nip_pkg::PulseW-1:0] pulse_width_i,
  input  nip_pkg::reg_file_t              regs_i,
  output nip_pkg::pulse_class_t           class_o
);

  function automatic logic in_win(input logic [nip_pkg::PulseW-1:0] w,
                                  input logic [nip_pkg::RegW-1:0]   lo,
                                  input logic [nip_pkg::RegW-1:0]   hi);
    in_win = (w > lo) && (w < hi);
  endfunction

  always_comb begin
    class_o.is_zero   = in_win(pulse_width_i, regs_i[nip_pkg::REG_ZERO_MIN],
                               regs_i[nip_pkg::REG_ZERO_MAX]);
    class_o.is_one    = in_win(pulse_width_i, regs_i[nip_pkg::REG_ONE_MIN],
                               regs_i[nip_pkg::REG_ONE_MAX]);
    class_o.is_repeat = in_win(pulse_width_i, regs_i[nip_pkg::REG_REPEAT_MIN],
                               regs_i[nip_pkg::REG_REPEAT_MAX]);
    class_o.is_leader = in_win(pulse_width_i, regs_i[nip_pkg::REG_LEADER_MIN],
                               regs_i[nip_pkg::REG_LEADER_MAX]);
  end

endmodule
`default_nettype wire

/* src/nip_core.sv */
// Decoder state, frame check on scan and the result register.
`default_nettype none
module nip_core #(
  parameter int unsigned TIMEOUT_TICKS = nip_pkg::TimeoutTicks
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       item_valid_i,
  input  nip_pkg::kind_e                  kind_i,
  input  nip_pkg::pulse_class_t           class_i,
  output logic                            item_taken_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [nip_pkg::ByteW-1:0]       key_code_o,
  output logic [nip_pkg::ByteW-1:0]       repeat_count_o,
  output logic                            leader_active_o
);

  localparam logic [nip_pkg::IdleW-1:0] IdleLimit = nip_pkg::IdleW'(TIMEOUT_TICKS);

  logic                          leader_q, leader_d;
  logic                          ready_q, ready_d;
  logic                          rise_q, rise_d;
  logic [nip_pkg::IdleW-1:0]     idle_q, idle_d;
  logic [nip_pkg::FrameW-1:0]    frame_q, frame_d;
  logic [nip_pkg::ByteW-1:0]     repeats_q, repeats_d;
  logic                          out_valid_q, out_valid_d;
  logic [nip_pkg::ByteW-1:0]     key_q, key_d;
  logic [nip_pkg::ByteW-1:0]     rep_out_q;
  logic                          lead_out_q;
  logic                          is_scan;
  logic                          stall;
  logic [nip_pkg::ByteW-1:0]     addr_b, addr_n, cmd_b, cmd_n;

  assign is_scan      = item_valid_i && (kind_i == nip_pkg::KIND_SCAN);
  assign stall        = is_scan && out_valid_q && !out_ready_i;
  assign item_taken_o = item_valid_i && !stall;

  assign addr_b = frame_q[31:24];
  assign addr_n = frame_q[23:16];
  assign cmd_b  = frame_q[15:8];
  assign cmd_n  = frame_q[7:0];

  always_comb begin
    leader_d  = leader_q;
    ready_d   = ready_q;
    rise_d    = rise_q;
    idle_d    = idle_q;
    frame_d   = frame_q;
    repeats_d = repeats_q;
    key_d     = '0;
    if (item_taken_o) begin
      unique case (kind_i)
        nip_pkg::KIND_RISE: begin
          rise_d = 1'b1;
        end
        nip_pkg::KIND_FALL: begin
          rise_d = 1'b0;
          if (rise_q) begin
            if (leader_q) begin
              priority if (class_i.is_zero) begin
                frame_d = {frame_q[nip_pkg::FrameW-2:0], 1'b0};
              end else if (class_i.is_one) begin
                frame_d = {frame_q[nip_pkg::FrameW-2:0], 1'b1};
              end else if (class_i.is_repeat) begin
                repeats_d = repeats_q + 8'd1;
                idle_d    = '0;
              end else begin
              end
            end else if (class_i.is_leader) begin
              leader_d  = 1'b1;
              repeats_d = '0;
            end
          end
        end
        nip_pkg::KIND_TICK: begin
          if (leader_q) begin
            rise_d = 1'b0;
            if (idle_q == '0) begin
              ready_d = 1'b1;
            end
            if (idle_q < IdleLimit) begin
              idle_d = idle_q + 4'd1;
            end else begin
              leader_d = 1'b0;
              idle_d   = '0;
            end
          end
        end
        nip_pkg::KIND_SCAN: begin
          if (ready_q) begin
            if ((addr_b == ~addr_n) && (cmd_b == ~cmd_n)) begin
              key_d = cmd_b;
            end
            if ((key_d == '0) || !leader_q) begin
              ready_d   = 1'b0;
              repeats_d = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (is_scan && item_taken_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leader_q    <= 1'b0;
      ready_q     <= 1'b0;
      rise_q      <= 1'b0;
      idle_q      <= '0;
      frame_q     <= '0;
      repeats_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      leader_q    <= leader_d;
      ready_q     <= ready_d;
      rise_q      <= rise_d;
      idle_q      <= idle_d;
      frame_q     <= frame_d;
      repeats_q   <= repeats_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_scan && item_taken_o) begin
      key_q      <= key_d;
      rep_out_q  <= repeats_d;
      lead_out_q <= leader_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign key_code_o      = key_q;
  assign repeat_count_o  = rep_out_q;
  assign leader_active_o = lead_out_q;

endmodule
`default_nettype wire
